/* sv/fpfa_pkg.sv */
package fpfa_pkg;

    localparam int OP_W     = 2;
    localparam int BIDX_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIRST = 2'd1;
    localparam logic [OP_W-1:0] OP_BEST  = 2'd2;
    localparam logic [OP_W-1:0] OP_WORST = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd2;

endpackage

/* sv/fixed_partition_fit_allocator_top.sv */
// Fixed-partition allocator. A load transaction writes one block size and frees the block.
// Its result is registered from the done state once the output register is free. A first, best
// or worst fit transaction scans blocks 0 .. L-1, where L = min(block_count, NUM_BLOCKS).
// It reads one size per cycle from the size memory and feeds it to a single compare unit.
// A load goes from idle straight to the done state, a fit through the scan state first. One
// transaction is in flight at a time; a new one is accepted while the previous result still
// waits on the output register. A stalled output holds the block in its result state until
// the output register frees up. block_count must be written only while idle; the block
// itself does not enforce this.
module fixed_partition_fit_allocator_top #(
    parameter int NUM_BLOCKS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fpfa_pkg::COUNT_W-1:0]         cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // op [1:0], block_index [5:2], amount [21:6], zero [23:22]
    input  logic [fpfa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status [1:0], chosen_block [5:2], zero [7:6]
    output logic [fpfa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import fpfa_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [COUNT_W-1:0]     block_count_reg;
    logic [OP_W-1:0]        op_reg;
    logic [BIDX_W-1:0]      bidx_reg;
    logic [AMOUNT_W-1:0]    amount_reg;
    logic                   in_range_reg;
    logic [CNT_W-1:0]       limit_reg;
    logic [CNT_W-1:0]       rd_idx_reg;
    logic                   pend_reg;
    logic [IDX_W-1:0]       pend_idx_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic [AMOUNT_W-1:0]    pick_size_reg;
    logic [NUM_BLOCKS-1:0]  taken_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [BIDX_W-1:0]      out_block_reg;

    logic [AMOUNT_W-1:0]    size_mem [NUM_BLOCKS];
    logic [AMOUNT_W-1:0]    size_q_reg;

    logic [OP_W-1:0]        in_op;
    logic [BIDX_W-1:0]      in_bidx;
    logic [AMOUNT_W-1:0]    in_amount;
    logic                   s_fire;
    logic                   out_free;
    logic                   in_range;
    logic                   mem_we;
    logic                   rd_go;
    logic                   fits;
    logic                   take;
    logic                   alloc_ok;

    assign in_op     = s_axis_tdata[1:0];
    assign in_bidx   = s_axis_tdata[5:2];
    assign in_amount = s_axis_tdata[21:6];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_range      = (32'(in_bidx) < NUM_BLOCKS);
    assign mem_we        = s_fire && (in_op == OP_LOAD) && in_range;
    assign rd_go         = (state_reg == S_SCAN) && (rd_idx_reg < limit_reg);

    // shared compare unit
    assign fits = (size_q_reg >= amount_reg);
    always_comb
    begin
        case (op_reg)
            OP_FIRST: take = fits && !found_reg;
            OP_BEST:  take = fits && (!found_reg || (size_q_reg < pick_size_reg));
            OP_WORST: take = !found_reg || (size_q_reg > pick_size_reg);
            default:  take = 1'b0;
        endcase
    end

    assign alloc_ok = found_reg && !((op_reg == OP_WORST) && (pick_size_reg < amount_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[IDX_W'(in_bidx)] <= in_amount;
        end
        size_q_reg <= size_mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= rd_idx_reg[IDX_W-1:0];
        if (s_fire)
        begin
            op_reg       <= in_op;
            bidx_reg     <= in_bidx;
            amount_reg   <= in_amount;
            in_range_reg <= in_range;
            if (32'(block_count_reg) > NUM_BLOCKS)
            begin
                limit_reg <= CNT_W'(NUM_BLOCKS);
            end
            else
            begin
                limit_reg <= CNT_W'(block_count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            block_count_reg <= COUNT_RESET;
            rd_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            pick_reg        <= '0;
            pick_size_reg   <= '0;
            taken_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_FAIL;
            out_block_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            if (out_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rd_idx_reg <= '0;
                    pend_reg   <= 1'b0;
                    found_reg  <= 1'b0;
                    if (s_fire)
                    begin
                        if (in_op == OP_LOAD)
                        begin
                            if (in_range)
                            begin
                                taken_reg[IDX_W'(in_bidx)] <= 1'b0;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= rd_go;
                    if (rd_go)
                    begin
                        rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    end
                    if (pend_reg && !taken_reg[pend_idx_reg] && take)
                    begin
                        found_reg     <= 1'b1;
                        pick_reg      <= pend_idx_reg;
                        pick_size_reg <= size_q_reg;
                    end
                    if (!rd_go && !pend_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (op_reg == OP_LOAD)
                        begin
                            out_status_reg <= in_range_reg ? ST_LOADED : ST_FAIL;
                            out_block_reg  <= in_range_reg ? bidx_reg : '0;
                        end
                        else if (alloc_ok)
                        begin
                            taken_reg[pick_reg] <= 1'b1;
                            out_status_reg      <= ST_ALLOC;
                            out_block_reg       <= BIDX_W'(pick_reg);
                        end
                        else
                        begin
                            out_status_reg <= ST_FAIL;
                            out_block_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_block_reg, out_status_reg};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("transaction accepted while busy");

    a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_FAIL) |-> (out_block_reg == '0))
        else $error("failed result carries nonzero block");

    a_alloc_marks_taken: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && out_status_reg == ST_ALLOC && op_reg != OP_LOAD)
            |-> taken_reg[pick_reg])
        else $error("allocated block not marked taken");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && found_reg) |-> (CNT_W'(pick_reg) < limit_reg))
        else $error("picked block beyond active count");

endmodule
